// ----- rtl/mspt_pkg.sv -----
// ----------------------------------------------------------------------------
// mspt_pkg: shared types and constants of the step position tracker
// Command and response payloads, command codes and configuration indexes.
// ----------------------------------------------------------------------------
package mspt_pkg;

	localparam int FIELD_W   = 24;
	localparam int CFG_W     = 24;
	localparam int POS_OUT_W = 16;
	localparam int STEP_W    = 16;
	localparam int FUNC_W    = 3;
	localparam int CHAN_W    = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 24'h808100;
	localparam logic [CFG_W-1:0] DRIVE_RESET  = 24'hFFFFFF;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK = 3'd0,
		FUNC_REL  = 3'd1,
		FUNC_ABS  = 3'd2,
		FUNC_STOP = 3'd3,
		FUNC_ZERO = 3'd4,
		FUNC_READ = 3'd5
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE = 1'b0,
		REG_DRIVE  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_REL  = 2'd1,
		MODE_ABS  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [CHAN_W-1:0]        channel;
		logic signed [STEP_W-1:0] step_count;
	} cmd_t;

	typedef struct packed {
		logic [FIELD_W-1:0]          move_up;
		logic [FIELD_W-1:0]          move_down;
		logic [FIELD_W-1:0]          heater_first_top;
		logic [FIELD_W-1:0]          heater_first_bottom;
		logic [FIELD_W-1:0]          heater_second_top;
		logic [FIELD_W-1:0]          heater_second_bottom;
		logic [1:0]                  motion_mode;
		logic signed [POS_OUT_W-1:0] position;
	} result_t;

endpackage

// ----- rtl/mspt_pos_mem.sv -----
// ----------------------------------------------------------------------------
// mspt_pos_mem: channel position store
// One write port, one read port with registered data. Per-entry valid bits
// make unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module mspt_pos_mem #(
	parameter int DEPTH = 24,
	parameter int WIDTH = 16,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- rtl/multichannel_step_position_tracker_core.sv -----
// ----------------------------------------------------------------------------
// multichannel_step_position_tracker_core: step position tracker
// Keeps a signed position per actuator channel and runs relative and
// absolute moves one tick at a time.
//
// Channels: commands arrive on cmd (valid/ready), one response per command
// leaves on rsp (valid/ready), and the two 24-bit masks are written on the
// cfg channel, which is always ready. cfg_index 0 selects the active mask,
// 1 the drive mask.
// A tick in absolute mode or with relative steps left walks the position
// store one channel per cycle through a single compare and increment unit,
// even when no channel ends up moving. A read of an existing channel passes
// a read step first; any other command that does not sweep goes straight to
// the finish step. Reset clears all positions, the mode and the counts, and
// loads the mask reset values; no clearing pass is needed. When the receiver
// stalls, the finished response waits in the output register while the next
// command is accepted; that command then holds at its last step until the
// output register frees up.
// ----------------------------------------------------------------------------
module multichannel_step_position_tracker_core #(
	parameter int CHANNELS       = 24,
	parameter int POSITION_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  mspt_pkg::cmd_t                  cmd_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output mspt_pkg::result_t               rsp_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mspt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mspt_pkg::CFG_W-1:0]      cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [AW-1:0] LAST = AW'(CHANNELS - 1);
	localparam int P = POSITION_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_READ,
		ST_FINISH
	} state_t;

	state_t                              state_q;
	mspt_pkg::mode_t                     mode_q;
	logic signed [mspt_pkg::STEP_W-1:0]  rem_q;
	logic [P-1:0]                        target_q;
	logic [mspt_pkg::CFG_W-1:0]          active_q;
	logic [mspt_pkg::CFG_W-1:0]          drive_q;
	logic                                abs_q;
	logic                                mv_up_q;
	logic                                mv_dn_q;
	logic [AW-1:0]                       idx_q;
	logic [AW-1:0]                       idx_s1;
	logic                                v_s1;
	logic [CHANNELS-1:0]                 up_q;
	logic [CHANNELS-1:0]                 down_q;
	logic signed [mspt_pkg::POS_OUT_W-1:0] pos_q;
	mspt_pkg::result_t                   rsp_q;
	logic                                rsp_valid_q;

	logic                                cmd_xfer;
	logic                                zero_all;
	logic                                chan_ok;
	logic [31:0]                         act32;
	logic [CHANNELS-1:0]                 act;
	logic [31:0]                         tgt_ext;
	logic [AW-1:0]                       rd_addr;
	logic [P-1:0]                        rd_data;
	logic [P-1:0]                        wr_data;
	logic                                up_b;
	logic                                dn_b;
	logic signed [31:0]                  pos_ext;
	logic [31:0]                         up32;
	logic [31:0]                         down32;
	logic [mspt_pkg::FIELD_W-1:0]        up24;
	logic [mspt_pkg::FIELD_W-1:0]        down24;
	mspt_pkg::mode_t                     fin_mode;
	mspt_pkg::result_t                   result;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign zero_all  = cmd_xfer && (cmd_data.func == mspt_pkg::FUNC_ZERO);
	assign chan_ok   = ({1'b0, cmd_data.channel} < (mspt_pkg::CHAN_W + 1)'(CHANNELS));
	assign act32     = 32'(active_q);
	assign act       = act32[CHANNELS-1:0];
	assign tgt_ext   = 32'(cmd_data.step_count);
	assign rd_addr   = (state_q == ST_IDLE) ? cmd_data.channel[AW-1:0] : idx_q;

	mspt_pos_mem #(
		.DEPTH(CHANNELS),
		.WIDTH(P),
		.AW   (AW)
	) u_pos_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (zero_all),
		.we    (v_s1),
		.waddr (idx_s1),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Shared step unit: in absolute mode a signed compare against the target,
	// and one increment or decrement per channel visited.
	always_comb begin
		if (abs_q) begin
			up_b = act[idx_s1] && ($signed(rd_data) > $signed(target_q));
			dn_b = act[idx_s1] && ($signed(rd_data) < $signed(target_q));
		end else begin
			up_b = act[idx_s1] && mv_up_q;
			dn_b = act[idx_s1] && mv_dn_q;
		end
		if (dn_b) begin
			wr_data = rd_data + P'(1);
		end else if (up_b) begin
			wr_data = rd_data - P'(1);
		end else begin
			wr_data = rd_data;
		end
	end

	assign pos_ext = 32'($signed(rd_data));

	always_comb begin
		up32     = 32'(up_q);
		down32   = 32'(down_q);
		up24     = up32[mspt_pkg::FIELD_W-1:0];
		down24   = down32[mspt_pkg::FIELD_W-1:0];
		fin_mode = (abs_q && (up_q == '0) && (down_q == '0)) ? mspt_pkg::MODE_IDLE : mode_q;
		result.move_up              = up24;
		result.move_down            = down24;
		result.heater_first_top     = down24 & drive_q;
		result.heater_first_bottom  = ~down24 & drive_q;
		result.heater_second_top    = up24 & drive_q;
		result.heater_second_bottom = ~up24 & drive_q;
		result.motion_mode          = fin_mode;
		result.position             = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= mspt_pkg::MODE_IDLE;
			rem_q       <= '0;
			target_q    <= '0;
			active_q    <= mspt_pkg::ACTIVE_RESET;
			drive_q     <= mspt_pkg::DRIVE_RESET;
			abs_q       <= 1'b0;
			mv_up_q     <= 1'b0;
			mv_dn_q     <= 1'b0;
			idx_q       <= '0;
			idx_s1      <= '0;
			v_s1        <= 1'b0;
			up_q        <= '0;
			down_q      <= '0;
			pos_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mspt_pkg::REG_ACTIVE: active_q <= cfg_data;
					mspt_pkg::REG_DRIVE:  drive_q  <= cfg_data;
					default: ;
				endcase
			end
			// The finish step drives the output valid itself.
			if (rsp_valid_q && rsp_ready && (state_q != ST_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			if (v_s1) begin
				up_q[idx_s1]   <= up_b;
				down_q[idx_s1] <= dn_b;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						up_q    <= '0;
						down_q  <= '0;
						pos_q   <= '0;
						abs_q   <= 1'b0;
						mv_up_q <= 1'b0;
						mv_dn_q <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_FINISH;
						case (cmd_data.func)
							mspt_pkg::FUNC_TICK: begin
								if (mode_q == mspt_pkg::MODE_REL) begin
									if (rem_q == '0) begin
										mode_q <= mspt_pkg::MODE_IDLE;
									end else if (rem_q > 0) begin
										mv_dn_q <= 1'b1;
										rem_q   <= rem_q - 16'sd1;
										state_q <= ST_SWEEP;
									end else begin
										mv_up_q <= 1'b1;
										rem_q   <= rem_q + 16'sd1;
										state_q <= ST_SWEEP;
									end
								end else if (mode_q == mspt_pkg::MODE_ABS) begin
									abs_q   <= 1'b1;
									state_q <= ST_SWEEP;
								end
							end
							mspt_pkg::FUNC_REL: begin
								mode_q <= mspt_pkg::MODE_REL;
								rem_q  <= cmd_data.step_count;
							end
							mspt_pkg::FUNC_ABS: begin
								mode_q   <= mspt_pkg::MODE_ABS;
								target_q <= tgt_ext[P-1:0];
							end
							mspt_pkg::FUNC_STOP: begin
								mode_q <= mspt_pkg::MODE_IDLE;
								rem_q  <= '0;
							end
							mspt_pkg::FUNC_READ: begin
								if (chan_ok) begin
									state_q <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					idx_s1 <= idx_q;
					v_s1   <= 1'b1;
					if (idx_q == LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					v_s1    <= 1'b0;
					state_q <= ST_FINISH;
				end
				ST_READ: begin
					pos_q   <= pos_ext[mspt_pkg::POS_OUT_W-1:0];
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= result;
						rsp_valid_q <= 1'b1;
						mode_q      <= fin_mode;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_wr_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (idx_s1 <= LAST))
		else $error("position write beyond the last channel");

	a_dir_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(up_q & down_q) == '0)
		else $error("a channel marked as stepping both up and down");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |-> !v_s1)
		else $error("command transfer while a position update is pending");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("response loaded outside the finish step");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the step position tracker core
// Drives commands with random gaps, stalls the response side at random, and
// compares every response field with a predictor that keeps its own copy of
// the channel positions, the motion state and both channel masks.
// ----------------------------------------------------------------------------
module testbench;

	localparam int N_CHAN      = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP     = 17;
	localparam int HOLD_CYCLES = 400;

	localparam logic [mspt_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [mspt_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

	class tracker_checker;
		logic [mspt_pkg::CFG_W-1:0]         active_mask;
		logic [mspt_pkg::CFG_W-1:0]         drive_mask;
		logic signed [mspt_pkg::STEP_W-1:0] pos [N_CHAN];
		mspt_pkg::mode_t                    mode;
		logic signed [mspt_pkg::STEP_W-1:0] steps_left;
		logic signed [mspt_pkg::STEP_W-1:0] goal;
		mspt_pkg::result_t                  expected_results[$];
		int                                 errors;

		function new();
			active_mask = mspt_pkg::ACTIVE_RESET;
			drive_mask = mspt_pkg::DRIVE_RESET;
			foreach (pos[i]) pos[i] = '0;
			mode = mspt_pkg::MODE_IDLE;
			steps_left = '0;
			goal = '0;
			errors = 0;
		endfunction

		function void write_reg(mspt_pkg::cfg_reg_t idx, logic [mspt_pkg::CFG_W-1:0] value);
			if (idx == mspt_pkg::REG_ACTIVE) active_mask = value;
			else drive_mask = value;
		endfunction

		// Works out the response of one accepted command and advances the state.
		function void note_command(mspt_pkg::cmd_t c);
			logic [mspt_pkg::FIELD_W-1:0] up;
			logic [mspt_pkg::FIELD_W-1:0] down;
			mspt_pkg::result_t r;
			up = '0;
			down = '0;
			r = '0;
			case (c.func)
			mspt_pkg::FUNC_TICK: begin
				if (mode == mspt_pkg::MODE_REL) begin
					if (steps_left == 0) begin
						mode = mspt_pkg::MODE_IDLE;
					end else if (steps_left > 0) begin
						down = active_mask;
						steps_left = steps_left - 16'sd1;
					end else begin
						up = active_mask;
						steps_left = steps_left + 16'sd1;
					end
				end else if (mode == mspt_pkg::MODE_ABS) begin
					for (int i = 0; i < N_CHAN; i++) begin
						if (active_mask[i]) begin
							if (pos[i] > goal) up[i] = 1'b1;
							else if (pos[i] < goal) down[i] = 1'b1;
						end
					end
					if ((up | down) == '0) mode = mspt_pkg::MODE_IDLE;
				end
				for (int i = 0; i < N_CHAN; i++) begin
					if (down[i]) pos[i] = pos[i] + 16'sd1;
					else if (up[i]) pos[i] = pos[i] - 16'sd1;
				end
			end
			mspt_pkg::FUNC_REL: begin
				mode = mspt_pkg::MODE_REL;
				steps_left = c.step_count;
			end
			mspt_pkg::FUNC_ABS: begin
				mode = mspt_pkg::MODE_ABS;
				goal = c.step_count;
			end
			mspt_pkg::FUNC_STOP: begin
				mode = mspt_pkg::MODE_IDLE;
				steps_left = '0;
			end
			mspt_pkg::FUNC_ZERO: begin
				foreach (pos[i]) pos[i] = '0;
			end
			mspt_pkg::FUNC_READ: begin
				if (c.channel < N_CHAN) r.position = pos[c.channel];
			end
			default: ;
			endcase
			r.move_up = up;
			r.move_down = down;
			r.heater_first_top = down & drive_mask;
			r.heater_first_bottom = ~down & drive_mask;
			r.heater_second_top = up & drive_mask;
			r.heater_second_bottom = ~up & drive_mask;
			r.motion_mode = mode;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", field, want, got);
				errors++;
			end
		endfunction

		function void check_response(mspt_pkg::result_t got);
			mspt_pkg::result_t want;
			if (expected_results.size() == 0) begin
				$error("response with no command outstanding: %h", got);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("move_up", 32'(want.move_up), 32'(got.move_up));
			compare_field("move_down", 32'(want.move_down), 32'(got.move_down));
			compare_field("heater_first_top", 32'(want.heater_first_top),
				32'(got.heater_first_top));
			compare_field("heater_first_bottom", 32'(want.heater_first_bottom),
				32'(got.heater_first_bottom));
			compare_field("heater_second_top", 32'(want.heater_second_top),
				32'(got.heater_second_top));
			compare_field("heater_second_bottom", 32'(want.heater_second_bottom),
				32'(got.heater_second_bottom));
			compare_field("motion_mode", 32'(want.motion_mode), 32'(got.motion_mode));
			compare_field("position", 32'(want.position), 32'(got.position));
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cmd_valid;
	logic                           cmd_ready;
	mspt_pkg::cmd_t                 cmd_data;
	logic                           rsp_valid;
	logic                           rsp_ready;
	mspt_pkg::result_t              rsp_data;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [mspt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mspt_pkg::CFG_W-1:0]     cfg_data;

	tracker_checker sb = new();
	int sent_count = 0;
	int rsp_count = 0;
	int cycle_count = 0;

	multichannel_step_position_tracker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic logic [mspt_pkg::STEP_W-1:0] rand_step();
		logic [31:0] r;
		r = $urandom;
		return r[mspt_pkg::STEP_W-1:0];
	endfunction

	function automatic logic [mspt_pkg::CFG_W-1:0] rand_mask();
		logic [31:0] r;
		r = $urandom;
		return r[mspt_pkg::CFG_W-1:0];
	endfunction

	function automatic mspt_pkg::cmd_t make_cmd(logic [mspt_pkg::FUNC_W-1:0] f,
		logic [mspt_pkg::STEP_W-1:0] s);
		mspt_pkg::cmd_t c;
		logic [31:0] r;
		r = $urandom;
		c.func = f;
		c.channel = r[mspt_pkg::CHAN_W-1:0];
		c.step_count = s;
		return c;
	endfunction

	// Every fourth stretch of 45 commands goes out back to back.
	task automatic send(mspt_pkg::cmd_t c);
		int gap;
		gap = ((sent_count / 45) % 4 == 3) ? 0 : int'($urandom_range(0, MAX_GAP));
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sb.note_command(c);
		sent_count++;
	endtask

	task automatic tick();
		send(make_cmd(mspt_pkg::FUNC_TICK, rand_step()));
	endtask

	task automatic read_at(logic [mspt_pkg::CHAN_W-1:0] ch);
		mspt_pkg::cmd_t c;
		c = make_cmd(mspt_pkg::FUNC_READ, rand_step());
		c.channel = ch;
		send(c);
	endtask

	task automatic quiesce();
		cmd_valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(mspt_pkg::cfg_reg_t idx, logic [mspt_pkg::CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [mspt_pkg::CFG_W-1:0] active,
		logic [mspt_pkg::CFG_W-1:0] drive);
		quiesce();
		write_reg(mspt_pkg::REG_ACTIVE, active);
		write_reg(mspt_pkg::REG_DRIVE, drive);
	endtask

	// Commands that break into a move: reads mostly, now and then a zero.
	task automatic interruption();
		case ($urandom_range(0, 5))
		0: send(make_cmd(mspt_pkg::FUNC_ZERO, rand_step()));
		default: send(make_cmd(mspt_pkg::FUNC_READ, rand_step()));
		endcase
	endtask

	task automatic relative_move();
		logic signed [mspt_pkg::STEP_W-1:0] count;
		int delta;
		int ticks;
		bit wide;
		wide = ($urandom_range(0, 4) == 0);
		if (wide) begin
			count = rand_step();
			ticks = int'($urandom_range(1, 6));
		end else begin
			delta = int'($urandom_range(0, 24)) - 12;
			count = delta[mspt_pkg::STEP_W-1:0];
			ticks = (delta < 0 ? -delta : delta) + int'($urandom_range(0, 2));
		end
		send(make_cmd(mspt_pkg::FUNC_REL, count));
		for (int k = 0; k < ticks; k++) begin
			if ($urandom_range(0, 14) == 0) interruption();
			tick();
		end
		if (wide && sb.mode == mspt_pkg::MODE_REL) send(make_cmd(mspt_pkg::FUNC_STOP, rand_step()));
	endtask

	task automatic absolute_move();
		logic signed [mspt_pkg::STEP_W-1:0] aim;
		int ch;
		int off;
		int n;
		ch = int'($urandom_range(0, N_CHAN - 1));
		off = int'($urandom_range(0, 12)) - 6;
		if ($urandom_range(0, 4) == 0) aim = rand_step();
		else aim = sb.pos[ch] + off[mspt_pkg::STEP_W-1:0];
		send(make_cmd(mspt_pkg::FUNC_ABS, aim));
		n = 0;
		while (sb.mode == mspt_pkg::MODE_ABS && n < 40) begin
			if ($urandom_range(0, 14) == 0) interruption();
			tick();
			n++;
		end
		if (sb.mode == mspt_pkg::MODE_ABS) send(make_cmd(mspt_pkg::FUNC_STOP, rand_step()));
	endtask

	task automatic stray_command();
		case ($urandom_range(0, 7))
		0: tick();
		1: send(make_cmd(mspt_pkg::FUNC_ZERO, rand_step()));
		2: send(make_cmd(mspt_pkg::FUNC_STOP, rand_step()));
		3: send(make_cmd($urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7, rand_step()));
		4: send(make_cmd(mspt_pkg::FUNC_REL, rand_step()));
		5: send(make_cmd(mspt_pkg::FUNC_ABS, rand_step()));
		default: send(make_cmd(mspt_pkg::FUNC_READ, rand_step()));
		endcase
	endtask

	task automatic random_phase(int n);
		int stop_at;
		stop_at = sent_count + n;
		while (sent_count < stop_at) begin
			case ($urandom_range(0, 9))
			0, 1, 2: relative_move();
			3, 4, 5: absolute_move();
			default: stray_command();
			endcase
		end
	endtask

	// Response side: random stalls, calm stretches, and two long hold-offs
	// that fill the core and back up the command channel.
	initial begin
		int stall;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_count == 100 || rsp_count == 380) stall = HOLD_CYCLES;
			else if ((rsp_count / 55) % 4 == 1) stall = 0;
			else stall = int'($urandom_range(0, MAX_GAP));
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			sb.check_response(rsp_data);
			rsp_count++;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= mspt_pkg::REG_ACTIVE;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset masks.
		read_at(5'd0);
		tick();
		send(make_cmd(mspt_pkg::FUNC_REL, 16'sd3));
		repeat (4) tick();
		send(make_cmd(mspt_pkg::FUNC_REL, -16'sd2));
		repeat (3) tick();
		read_at(5'd8);
		read_at(5'd31);
		send(make_cmd(mspt_pkg::FUNC_ABS, 16'sh7FFF));
		tick();
		send(make_cmd(mspt_pkg::FUNC_STOP, rand_step()));
		send(make_cmd(mspt_pkg::FUNC_ABS, 16'sh8000));
		tick();
		send(make_cmd(mspt_pkg::FUNC_STOP, rand_step()));
		send(make_cmd(mspt_pkg::FUNC_REL, 16'sh7FFF));
		tick();
		send(make_cmd(mspt_pkg::FUNC_STOP, rand_step()));
		send(make_cmd(mspt_pkg::FUNC_REL, 16'sh8000));
		tick();
		send(make_cmd(mspt_pkg::FUNC_STOP, rand_step()));
		send(make_cmd(mspt_pkg::FUNC_ZERO, rand_step()));
		read_at(5'd23);
		send(make_cmd(FUNC_SPARE_6, rand_step()));
		send(make_cmd(FUNC_SPARE_7, rand_step()));

		configure(24'hFFFFFF, rand_mask());
		random_phase(125);
		configure(rand_mask(), 24'h000000);
		random_phase(125);
		// No channel takes part, so every absolute move ends on its first tick.
		configure(24'h000000, 24'hFFFFFF);
		random_phase(30);
		configure(rand_mask(), rand_mask());
		random_phase(125);

		quiesce();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/mspt_pkg.sv
rtl/mspt_pos_mem.sv
rtl/multichannel_step_position_tracker_core.sv
tb/sv/testbench.sv
